// ===== hdl/dmec_pkg.sv =====
// ----------------------------------------------------------------------------
// Device mode event controller package
// Shared types, codes and defaults of the mode and event controller.
// ----------------------------------------------------------------------------
package dmec_pkg;

	localparam int QUEUE_DEPTH_DEF  = 4;
	localparam int ACTION_COUNT_DEF = 3;

	localparam logic [1:0] REQ_POST    = 2'd0;
	localparam logic [1:0] REQ_MODE    = 2'd1;
	localparam logic [1:0] REQ_ACTION  = 2'd2;
	localparam logic [1:0] REQ_PROCESS = 2'd3;

	localparam logic [2:0] EV_PRESS      = 3'd0;
	localparam logic [2:0] EV_RELEASE    = 3'd1;
	localparam logic [2:0] EV_HOLD       = 3'd2;
	localparam logic [2:0] EV_VBUS_HIGH  = 3'd3;
	localparam logic [2:0] EV_VBUS_LOW   = 3'd4;
	localparam logic [2:0] EV_FORCE      = 3'd5;
	localparam logic [2:0] EV_REQ_MODE   = 3'd6;
	localparam logic [2:0] EV_REQ_ACTION = 3'd7;

	localparam logic [2:0] MODE_SLEEP   = 3'd0;
	localparam logic [2:0] MODE_ACTIVE  = 3'd1;
	localparam logic [2:0] MODE_CONFIG  = 3'd2;
	localparam logic [2:0] MODE_USB     = 3'd3;
	localparam logic [2:0] MODE_PAIRING = 3'd4;
	localparam logic [2:0] MODE_START   = 3'd5;
	localparam logic [2:0] MODE_NONE    = 3'd6;

	localparam logic [1:0] RES_OK          = 2'd0;
	localparam logic [1:0] RES_INVALID     = 2'd1;
	localparam logic [1:0] RES_BUSY        = 2'd2;
	localparam logic [1:0] RES_NOT_ALLOWED = 2'd3;

	localparam logic [1:0] TMR_NONE  = 2'd0;
	localparam logic [1:0] TMR_START = 2'd1;
	localparam logic [1:0] TMR_STOP  = 2'd2;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_INSTALL = 2'd1;

	localparam logic [0:0] REG_BLE_ENABLED  = 1'b0;
	localparam logic [0:0] REG_HOLD_START   = 1'b1;

	typedef enum logic [5:0] {
		M_SLEEP   = 6'b000001,
		M_ACTIVE  = 6'b000010,
		M_CONFIG  = 6'b000100,
		M_USB     = 6'b001000,
		M_PAIRING = 6'b010000,
		M_START   = 6'b100000
	} mode_state_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_FIRST    = 4'b0010,
		PH_RELEASED = 4'b0100,
		PH_SECOND   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] event_code;
		logic [2:0] target_mode;
		logic [1:0] action_code;
	} item_t;

	typedef struct packed {
		logic [1:0] request_result;
		logic [2:0] current_mode;
		logic [2:0] previous_mode;
		logic       mode_changed;
		logic [1:0] timer_command;
		logic       reset_request;
		logic       loader_install;
		logic       event_processed;
		logic       queue_overflowed;
		logic       queue_empty;
	} result_t;

	typedef struct packed {
		logic ble_enabled;
		logic hold_enters_start;
	} cfg_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [2:0] data;
	} q_cmd_t;

	typedef struct packed {
		logic [2:0] head;
		logic       empty;
		logic       single;
		logic       full;
	} q_stat_t;

	function automatic logic [2:0] mode_code(input mode_state_t m);
		logic [2:0] c;
		case (m)
			M_SLEEP:   c = MODE_SLEEP;
			M_ACTIVE:  c = MODE_ACTIVE;
			M_CONFIG:  c = MODE_CONFIG;
			M_USB:     c = MODE_USB;
			M_PAIRING: c = MODE_PAIRING;
			M_START:   c = MODE_START;
			default:   c = MODE_SLEEP;
		endcase
		return c;
	endfunction

	function automatic mode_state_t mode_from_code(input logic [2:0] c);
		mode_state_t m;
		case (c)
			MODE_ACTIVE:  m = M_ACTIVE;
			MODE_CONFIG:  m = M_CONFIG;
			MODE_USB:     m = M_USB;
			MODE_PAIRING: m = M_PAIRING;
			MODE_START:   m = M_START;
			default:      m = M_SLEEP;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/device_mode_event_controller.sv =====
// ----------------------------------------------------------------------------
// Device mode event controller
// Six-mode controller with a small event queue, request checks and the
// button decoder used in sleep.
// ----------------------------------------------------------------------------
// Each item on the item channel is a posted event, a mode request, a
// terminal-action request or an instruction to process one queued event.
// Every item produces exactly one transfer on the result channel.
// An accepted item is captured in the input register, is evaluated
// against the controller state and the queue head, and its result is held
// in the output register.
// One item is accepted per cycle while the receiver does not stall, set by
// the single decision stage that updates the mode, pending requests and queue pointers together.
// The two configuration bits are written through the APB-style port and
// read back; the user must write them only while the block is idle, which the block does not enforce.
// Reset returns the mode to sleep, clears pending requests and empties the
// queue; the configuration bits return to zero.
// When the receiver stalls, the result is held and the input register stays
// full, so item_stall rises in the same cycle and no transfer is lost.
// ----------------------------------------------------------------------------
module device_mode_event_controller #(
	parameter int QUEUE_DEPTH  = dmec_pkg::QUEUE_DEPTH_DEF,
	parameter int ACTION_COUNT = dmec_pkg::ACTION_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  dmec_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output dmec_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	dmec_pkg::item_t   item_s1;
	logic              valid_s1;
	dmec_pkg::result_t result_q;
	logic              result_valid_q;
	dmec_pkg::cfg_t    cfg_q;
	dmec_pkg::q_cmd_t  qcmd;
	dmec_pkg::q_stat_t qstat;
	dmec_pkg::result_t core_result;
	logic              advance;
	logic              fire;
	logic              cfg_write;

	assign advance    = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == dmec_pkg::REG_HOLD_START)
		? {31'b0, cfg_q.hold_enters_start} : {31'b0, cfg_q.ble_enabled};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			if (paddr[2] == dmec_pkg::REG_BLE_ENABLED) begin
				cfg_q.ble_enabled <= pwdata[0];
			end else begin
				cfg_q.hold_enters_start <= pwdata[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (fire) begin
			result_q <= core_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	dmec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qcmd),
		.stat   (qstat)
	);

	dmec_core #(
		.ACTION_COUNT (ACTION_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.qcmd   (qcmd),
		.result (core_result)
	);

endmodule

// ===== hdl/dmec_queue.sv =====
// ----------------------------------------------------------------------------
// Event queue
// Circular event store that drops its oldest entry when pushed while full.
// ----------------------------------------------------------------------------
module dmec_queue #(
	parameter int DEPTH = dmec_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dmec_pkg::q_cmd_t cmd,
	output dmec_pkg::q_stat_t stat
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);

	logic [2:0]    store_q [DEPTH];
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] wr_idx_q;
	logic [CW-1:0] count_q;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
		return (idx == LastIdx) ? '0 : idx + IW'(1);
	endfunction

	assign stat.head   = store_q[rd_idx_q];
	assign stat.empty  = (count_q == '0);
	assign stat.single = (count_q == CW'(1));
	assign stat.full   = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			store_q[wr_idx_q] <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			count_q  <= '0;
		end else if (cmd.push) begin
			wr_idx_q <= wrap_inc(wr_idx_q);
			if (stat.full) begin
				rd_idx_q <= wrap_inc(rd_idx_q);
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (cmd.pop) begin
			rd_idx_q <= wrap_inc(rd_idx_q);
			count_q  <= count_q - CW'(1);
		end
	end

endmodule

// ===== hdl/dmec_core.sv =====
// ----------------------------------------------------------------------------
// Mode controller core
// Request checking, per-mode event handling and the controller state.
// ----------------------------------------------------------------------------
module dmec_core #(
	parameter int ACTION_COUNT = dmec_pkg::ACTION_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  dmec_pkg::item_t    item,
	input  dmec_pkg::cfg_t     cfg,
	input  dmec_pkg::q_stat_t  qstat,
	output dmec_pkg::q_cmd_t   qcmd,
	output dmec_pkg::result_t  result
);

	localparam logic [2:0] ActLimit = 3'(ACTION_COUNT);

	dmec_pkg::mode_state_t mode_q, mode_n, nxt;
	dmec_pkg::phase_t      phase_q, phase_n;
	logic [2:0] pend_mode_q, pend_mode_n;
	logic [1:0] pend_act_q, pend_act_n;
	logic [1:0] res;
	logic [1:0] tmr;
	logic       rst_req;
	logic       ldr;
	logic       processed;
	logic       push;
	logic       pop;
	logic [2:0] pdata;
	logic [2:0] ev;
	logic       busy;

	always_comb begin
		mode_n      = mode_q;
		phase_n     = phase_q;
		pend_mode_n = pend_mode_q;
		pend_act_n  = pend_act_q;
		nxt         = mode_q;
		res         = dmec_pkg::RES_OK;
		tmr         = dmec_pkg::TMR_NONE;
		rst_req     = 1'b0;
		ldr         = 1'b0;
		processed   = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		pdata       = item.event_code;
		ev          = qstat.head;
		busy        = (pend_mode_q != dmec_pkg::MODE_NONE) || (pend_act_q != dmec_pkg::ACT_NONE);

		case (item.req_type)
			dmec_pkg::REQ_POST: begin
				push = (item.event_code <= dmec_pkg::EV_FORCE);
			end
			dmec_pkg::REQ_MODE: begin
				if (item.target_mode >= dmec_pkg::MODE_NONE) begin
					res = dmec_pkg::RES_INVALID;
				end else if (busy) begin
					res = dmec_pkg::RES_BUSY;
				end else if (mode_q == dmec_pkg::M_USB
						|| item.target_mode == dmec_pkg::MODE_USB) begin
					res = dmec_pkg::RES_NOT_ALLOWED;
				end else if (mode_q != dmec_pkg::M_SLEEP
						&& item.target_mode != dmec_pkg::MODE_SLEEP) begin
					res = dmec_pkg::RES_NOT_ALLOWED;
				end
				if (res == dmec_pkg::RES_OK) begin
					pend_mode_n = item.target_mode;
					phase_n     = dmec_pkg::PH_IDLE;
					push        = 1'b1;
					pdata       = dmec_pkg::EV_REQ_MODE;
				end
			end
			dmec_pkg::REQ_ACTION: begin
				if (item.action_code == dmec_pkg::ACT_NONE
						|| {1'b0, item.action_code} >= ActLimit) begin
					res = dmec_pkg::RES_INVALID;
				end else if (busy) begin
					res = dmec_pkg::RES_BUSY;
				end else if (mode_q == dmec_pkg::M_USB) begin
					res = dmec_pkg::RES_NOT_ALLOWED;
				end
				if (res == dmec_pkg::RES_OK) begin
					pend_act_n = item.action_code;
					phase_n    = dmec_pkg::PH_IDLE;
					push       = 1'b1;
					pdata      = dmec_pkg::EV_REQ_ACTION;
				end
			end
			default: begin
				if (!qstat.empty) begin
					pop       = 1'b1;
					processed = 1'b1;
					case (mode_q)
						dmec_pkg::M_SLEEP: begin
							case (ev)
								dmec_pkg::EV_PRESS: begin
									if (phase_q == dmec_pkg::PH_IDLE) begin
										phase_n = dmec_pkg::PH_FIRST;
									end else if (phase_q == dmec_pkg::PH_RELEASED) begin
										phase_n = dmec_pkg::PH_SECOND;
									end
									tmr = dmec_pkg::TMR_START;
								end
								dmec_pkg::EV_RELEASE: begin
									phase_n = dmec_pkg::PH_IDLE;
									if (phase_q == dmec_pkg::PH_FIRST) begin
										phase_n = dmec_pkg::PH_RELEASED;
									end else if (phase_q == dmec_pkg::PH_SECOND
											&& cfg.ble_enabled) begin
										nxt = dmec_pkg::M_PAIRING;
									end
								end
								dmec_pkg::EV_HOLD: begin
									phase_n = dmec_pkg::PH_IDLE;
									if (phase_q == dmec_pkg::PH_FIRST) begin
										nxt = cfg.hold_enters_start ? dmec_pkg::M_START
											: dmec_pkg::M_ACTIVE;
									end else if (phase_q == dmec_pkg::PH_SECOND) begin
										nxt = dmec_pkg::M_CONFIG;
									end
								end
								dmec_pkg::EV_VBUS_HIGH: begin
									nxt = dmec_pkg::M_USB;
								end
								dmec_pkg::EV_REQ_MODE: begin
									pend_mode_n = dmec_pkg::MODE_NONE;
									tmr         = dmec_pkg::TMR_STOP;
									phase_n     = dmec_pkg::PH_IDLE;
									if (pend_mode_q == dmec_pkg::MODE_ACTIVE
											|| pend_mode_q == dmec_pkg::MODE_CONFIG
											|| pend_mode_q == dmec_pkg::MODE_PAIRING
											|| pend_mode_q == dmec_pkg::MODE_START) begin
										nxt = dmec_pkg::mode_from_code(pend_mode_q);
									end
								end
								default: begin
									nxt = dmec_pkg::M_SLEEP;
								end
							endcase
						end
						dmec_pkg::M_ACTIVE, dmec_pkg::M_START: begin
							case (ev)
								dmec_pkg::EV_PRESS: begin
									tmr = dmec_pkg::TMR_START;
								end
								dmec_pkg::EV_RELEASE: begin
									tmr = dmec_pkg::TMR_STOP;
								end
								dmec_pkg::EV_HOLD: begin
									nxt = dmec_pkg::M_SLEEP;
								end
								dmec_pkg::EV_REQ_MODE: begin
									if (pend_mode_q == dmec_pkg::MODE_SLEEP) begin
										tmr = dmec_pkg::TMR_STOP;
										nxt = dmec_pkg::M_SLEEP;
									end
									pend_mode_n = dmec_pkg::MODE_NONE;
								end
								dmec_pkg::EV_REQ_ACTION: begin
									tmr = dmec_pkg::TMR_STOP;
									nxt = dmec_pkg::M_SLEEP;
								end
								default: begin
									nxt = mode_q;
								end
							endcase
						end
						dmec_pkg::M_USB: begin
							case (ev)
								dmec_pkg::EV_VBUS_LOW: begin
									nxt = dmec_pkg::M_SLEEP;
								end
								dmec_pkg::EV_REQ_MODE: begin
									pend_mode_n = dmec_pkg::MODE_NONE;
								end
								dmec_pkg::EV_REQ_ACTION: begin
									pend_act_n = dmec_pkg::ACT_NONE;
								end
								default: begin
									nxt = dmec_pkg::M_USB;
								end
							endcase
						end
						default: begin
							case (ev)
								dmec_pkg::EV_PRESS, dmec_pkg::EV_FORCE,
								dmec_pkg::EV_REQ_ACTION: begin
									nxt = dmec_pkg::M_SLEEP;
								end
								dmec_pkg::EV_REQ_MODE: begin
									if (pend_mode_q == dmec_pkg::MODE_SLEEP) begin
										nxt = dmec_pkg::M_SLEEP;
									end
									pend_mode_n = dmec_pkg::MODE_NONE;
								end
								default: begin
									nxt = mode_q;
								end
							endcase
						end
					endcase
					mode_n = nxt;
					if (pend_act_n != dmec_pkg::ACT_NONE && mode_n == dmec_pkg::M_SLEEP) begin
						rst_req    = 1'b1;
						ldr        = (pend_act_n == dmec_pkg::ACT_INSTALL);
						pend_act_n = dmec_pkg::ACT_NONE;
					end
				end
			end
		endcase
	end

	assign qcmd.push = fire && push;
	assign qcmd.pop  = fire && pop;
	assign qcmd.data = pdata;

	assign result.request_result   = res;
	assign result.current_mode     = dmec_pkg::mode_code(mode_n);
	assign result.previous_mode    = dmec_pkg::mode_code(mode_q);
	assign result.mode_changed     = (mode_n != mode_q);
	assign result.timer_command    = tmr;
	assign result.reset_request    = rst_req;
	assign result.loader_install   = ldr;
	assign result.event_processed  = processed;
	assign result.queue_overflowed = push && qstat.full;
	assign result.queue_empty      = push ? 1'b0 : (pop ? qstat.single : qstat.empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= dmec_pkg::M_SLEEP;
			phase_q     <= dmec_pkg::PH_IDLE;
			pend_mode_q <= dmec_pkg::MODE_NONE;
			pend_act_q  <= dmec_pkg::ACT_NONE;
		end else if (fire) begin
			mode_q      <= mode_n;
			phase_q     <= phase_n;
			pend_mode_q <= pend_mode_n;
			pend_act_q  <= pend_act_n;
		end
	end

endmodule

// ===== hdl/dmec_checker.sv =====
// ----------------------------------------------------------------------------
// Device mode event controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dmec_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input dmec_pkg::result_t result
);

	// A stalled result transfer must be presented again unchanged.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.current_mode <= dmec_pkg::MODE_START
			&& result.previous_mode <= dmec_pkg::MODE_START)
		else $error("mode outside the defined set");

	a_idle_effects: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.event_processed |->
			!result.mode_changed && !result.reset_request
			&& result.timer_command == dmec_pkg::TMR_NONE)
		else $error("mode effect without a processed event");

	a_reset_in_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.reset_request |->
			result.current_mode == dmec_pkg::MODE_SLEEP)
		else $error("reset requested outside sleep");

	a_loader_with_reset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.loader_install |-> result.reset_request)
		else $error("loader flag without a reset request");

endmodule

bind device_mode_event_controller dmec_checker u_dmec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
